### design/fsc_pkg.sv
// Package with shared constants, types and mode codes for the fp32 binary scale block.
`timescale 1ns / 1ps

package fsc_pkg;

    localparam int unsigned FracBits = 23;
    localparam int unsigned ExpBits  = 8;
    localparam int unsigned WordBits = 32;
    localparam int unsigned ScaleBits = 64;

    // Scale is saturated to this signed width; every decision is unchanged by it.
    localparam int unsigned SatBits  = 10;
    // Width of exponent arithmetic in the middle stage.
    localparam int unsigned SumBits  = 11;
    // Right-shift amounts saturate at the top of this width.
    localparam int unsigned AmtBits  = 6;
    localparam int unsigned LzBits   = 5;

    localparam logic [ExpBits-1:0] ExpMax = 8'd255;

    typedef logic [2:0] mode_t;

    localparam mode_t MODE_PASS  = 3'd0;
    localparam mode_t MODE_INF   = 3'd1;
    localparam mode_t MODE_NORM  = 3'd2;
    localparam mode_t MODE_SHL   = 3'd3;
    localparam mode_t MODE_RND   = 3'd4;
    localparam mode_t MODE_TRUNC = 3'd5;

    // Operand classes decided in the first stage.
    typedef logic [1:0] class_t;

    localparam class_t CLS_PASS = 2'd0;
    localparam class_t CLS_DEN  = 2'd1;
    localparam class_t CLS_NORM = 2'd2;

endpackage

### design/fsc_in_if.sv
// Operand channel: valid/ready handshake with the value and scale payload.
`timescale 1ns / 1ps

interface fsc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_bits;
    logic signed [63:0] scale_power;

    modport source (output valid, output value_bits, output scale_power, input ready);
    modport sink   (input valid, input value_bits, input scale_power, output ready);
endinterface

### design/fsc_out_if.sv
// Result channel: valid/ready handshake with the scaled value and flags.
`timescale 1ns / 1ps

interface fsc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_bits;
    logic        overflow_flag;
    logic        underflow_flag;

    modport source (output valid, output result_bits, output overflow_flag,
                    output underflow_flag, input ready);
    modport sink   (input valid, input result_bits, input overflow_flag,
                    input underflow_flag, output ready);
endinterface

### design/fsc_lzc.sv
// Leading-zero counter over the 23-bit fraction field.
`timescale 1ns / 1ps

module fsc_lzc
    import fsc_pkg::*;
(
    input  logic [FracBits-1:0] frac,
    output logic [LzBits-1:0]   count
);

    // Priority search from the top bit; an all-zero field counts as full width.
    always_comb
    begin
        count = LzBits'(FracBits);
        for (int b = 0; b < FracBits; b++)
        begin
            if (frac[b])
            begin
                count = LzBits'(FracBits - 1 - b);
            end
        end
    end

endmodule

### design/fp32_binary_scale.sv
// Top level of the fp32 binary scale pipeline.
`timescale 1ns / 1ps

// Multiplies an IEEE single-precision value by two to a signed 64-bit power.
// NaN, infinity and zero pass through; denormals are renormalized, shifted
// right with round-half-up or overflow to signed infinity; normals overflow to
// signed infinity (overflow flag) or underflow to a truncated denormal
// (underflow flag). The block is a three-stage pipeline: classify and saturate
// the scale, exponent arithmetic, then shift and assemble. One operation is
// accepted per cycle while results are taken; a stalled result holds its
// stage and the stages behind it fill before the operand side sees ready drop.
module fp32_binary_scale
    import fsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    fsc_in_if.sink     req,
    fsc_out_if.source  rsp
);

    // Stage load enables; each stage advances when its successor has room.
    logic ld1, ld2, ld3;
    logic v1_reg, v2_reg, v3_reg;

    assign ld3 = !v3_reg || rsp.ready;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;
    assign req.ready = ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ld1) v1_reg <= req.valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
        end
    end

    // ---------------- Stage 1: classify, saturate scale, count zeros ----------------
    logic [ExpBits-1:0]  exp_in;
    logic [FracBits-1:0] frac_in;
    logic [LzBits-1:0]   lz_in;
    logic signed [SatBits-1:0] sat_next;
    class_t cls_next;

    assign exp_in  = req.value_bits[WordBits-2:FracBits];
    assign frac_in = req.value_bits[FracBits-1:0];

    fsc_lzc u_lzc
    (
        .frac  (frac_in),
        .count (lz_in)
    );

    // Values outside the saturated range give the same result as its ends.
    always_comb
    begin
        if (!req.scale_power[ScaleBits-1] && (|req.scale_power[ScaleBits-2:SatBits-1]))
        begin
            sat_next = {1'b0, {(SatBits-1){1'b1}}};
        end
        else if (req.scale_power[ScaleBits-1] && !(&req.scale_power[ScaleBits-2:SatBits-1]))
        begin
            sat_next = {1'b1, {(SatBits-1){1'b0}}};
        end
        else
        begin
            sat_next = req.scale_power[SatBits-1:0];
        end
    end

    always_comb
    begin
        if (exp_in == ExpMax || req.value_bits[WordBits-2:0] == '0)
        begin
            cls_next = CLS_PASS;
        end
        else if (exp_in == '0)
        begin
            cls_next = CLS_DEN;
        end
        else
        begin
            cls_next = CLS_NORM;
        end
    end

    logic [WordBits-1:0]       val1_reg;
    logic signed [SatBits-1:0] sat1_reg;
    class_t                    cls1_reg;
    logic [LzBits-1:0]         lz1_reg;

    always_ff @(posedge clk)
    begin
        if (ld1 && req.valid)
        begin
            val1_reg <= req.value_bits;
            sat1_reg <= sat_next;
            cls1_reg <= cls_next;
            lz1_reg  <= lz_in;
        end
    end

    // ---------------- Stage 2: exponent arithmetic and shift amounts ----------------
    logic signed [SumBits-1:0] s_ext, lz_ext, e_ext, ex_up, sum_n, n_shr;
    mode_t               mode_next;
    logic [AmtBits-1:0]  amt_next;
    logic [ExpBits-1:0]  exp_next;
    logic                ovf_next, unf_next;

    assign s_ext  = SumBits'(sat1_reg);
    assign lz_ext = SumBits'({1'b0, lz1_reg});
    assign e_ext  = SumBits'({1'b0, val1_reg[WordBits-2:FracBits]});
    assign ex_up  = s_ext - lz_ext;
    assign sum_n  = e_ext + s_ext;

    always_comb
    begin
        mode_next = MODE_PASS;
        amt_next  = '0;
        exp_next  = '0;
        ovf_next  = 1'b0;
        unf_next  = 1'b0;
        n_shr     = '0;
        case (cls1_reg)
            CLS_DEN:
            begin
                if (s_ext > 0)
                begin
                    // Renormalize: short shifts stay denormal, longer ones gain exponent or overflow.
                    if (s_ext <= lz_ext)
                    begin
                        mode_next = MODE_SHL;
                        amt_next  = AmtBits'(sat1_reg[LzBits-1:0]);
                    end
                    else if (ex_up >= $signed(SumBits'(ExpMax)))
                    begin
                        mode_next = MODE_INF;
                    end
                    else
                    begin
                        mode_next = MODE_SHL;
                        amt_next  = AmtBits'(lz1_reg) + AmtBits'(1);
                        exp_next  = ex_up[ExpBits-1:0];
                    end
                end
                else
                begin
                    mode_next = MODE_RND;
                    n_shr     = -s_ext;
                end
            end
            CLS_NORM:
            begin
                if (sum_n >= $signed(SumBits'(ExpMax)))
                begin
                    mode_next = MODE_INF;
                    ovf_next  = 1'b1;
                end
                else if (sum_n <= 0)
                begin
                    mode_next = MODE_TRUNC;
                    unf_next  = 1'b1;
                    n_shr     = SumBits'(1) - sum_n;
                end
                else
                begin
                    mode_next = MODE_NORM;
                    exp_next  = sum_n[ExpBits-1:0];
                end
            end
            default:
            begin
                mode_next = MODE_PASS;
            end
        endcase
        // Right shifts saturate; anything this long already clears the fraction.
        if (mode_next == MODE_RND || mode_next == MODE_TRUNC)
        begin
            if (n_shr > SumBits'({AmtBits{1'b1}}))
            begin
                amt_next = '1;
            end
            else
            begin
                amt_next = n_shr[AmtBits-1:0];
            end
        end
    end

    logic [WordBits-1:0] val2_reg;
    mode_t               mode2_reg;
    logic [AmtBits-1:0]  amt2_reg;
    logic [ExpBits-1:0]  exp2_reg;
    logic                ovf2_reg, unf2_reg;

    always_ff @(posedge clk)
    begin
        if (ld2 && v1_reg)
        begin
            val2_reg  <= val1_reg;
            mode2_reg <= mode_next;
            amt2_reg  <= amt_next;
            exp2_reg  <= exp_next;
            ovf2_reg  <= ovf_next;
            unf2_reg  <= unf_next;
        end
    end

    // ---------------- Stage 3: fraction shift and result assembly ----------------
    logic                sgn2;
    logic [FracBits:0]   mant2;
    logic [WordBits-1:0] shl_w, shr_w, rbit_w, res_next;

    assign sgn2  = val2_reg[WordBits-1];
    assign mant2 = (mode2_reg == MODE_TRUNC) ? {1'b1, val2_reg[FracBits-1:0]}
                                             : {1'b0, val2_reg[FracBits-1:0]};
    assign shl_w = WordBits'(mant2) << amt2_reg;
    assign shr_w = WordBits'(mant2) >> amt2_reg;
    assign rbit_w = WordBits'(mant2) >> (amt2_reg - AmtBits'(1));

    always_comb
    begin
        case (mode2_reg)
            MODE_INF:   res_next = {sgn2, ExpMax, {FracBits{1'b0}}};
            MODE_NORM:  res_next = {sgn2, exp2_reg, val2_reg[FracBits-1:0]};
            MODE_SHL:   res_next = {sgn2, exp2_reg, shl_w[FracBits-1:0]};
            MODE_RND:
            begin
                // Round half up on the last bit shifted out.
                if (amt2_reg != '0 && rbit_w[0])
                begin
                    res_next = {sgn2, {ExpBits{1'b0}},
                                shr_w[FracBits-1:0] + FracBits'(1)};
                end
                else
                begin
                    res_next = {sgn2, {ExpBits{1'b0}}, shr_w[FracBits-1:0]};
                end
            end
            MODE_TRUNC: res_next = {sgn2, {ExpBits{1'b0}}, shr_w[FracBits-1:0]};
            default:    res_next = val2_reg;
        endcase
    end

    logic [WordBits-1:0] res3_reg;
    logic                ovf3_reg, unf3_reg;

    always_ff @(posedge clk)
    begin
        if (ld3 && v2_reg)
        begin
            res3_reg <= res_next;
            ovf3_reg <= ovf2_reg;
            unf3_reg <= unf2_reg;
        end
    end

    assign rsp.valid          = v3_reg;
    assign rsp.result_bits    = res3_reg;
    assign rsp.overflow_flag  = ovf3_reg;
    assign rsp.underflow_flag = unf3_reg;

endmodule
